// ===== rtl/core/cvpm_pkg.sv =====
// Shared types, codes and helpers for the color vision pixel mode mapper.
package cvpm_pkg;

    localparam int STRIP_HEIGHT_DEF = 64;
    localparam int ROW_BITS_DEF     = 12;

    localparam int PIX_W      = 8;
    localparam int TOOL_SHIFT = 60;
    localparam int PIX_MAX    = 255;

    // display modes
    localparam logic [3:0] MODE_ORIG     = 4'd0;
    localparam logic [3:0] MODE_RED      = 4'd1;
    localparam logic [3:0] MODE_GREEN    = 4'd2;
    localparam logic [3:0] MODE_BLUE     = 4'd3;
    localparam logic [3:0] MODE_CONE     = 4'd4;
    localparam logic [3:0] MODE_LUMA     = 4'd5;
    localparam logic [3:0] MODE_RG_DIFF  = 4'd6;
    localparam logic [3:0] MODE_RG_AVG   = 4'd7;
    localparam logic [3:0] MODE_YB_GRAY  = 4'd8;
    localparam logic [3:0] MODE_YB_YEL   = 4'd9;
    localparam logic [3:0] MODE_R_HALF_G = 4'd10;
    localparam logic [3:0] MODE_STRIP    = 4'd11;

    // channel selectors
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // post tools
    localparam logic [1:0] TOOL_NONE  = 2'd0;
    localparam logic [1:0] TOOL_DARK  = 2'd1;
    localparam logic [1:0] TOOL_LIGHT = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_COLOR_PROFILE = 3'd1;
    localparam logic [2:0] REG_TOOL          = 3'd2;
    localparam logic [2:0] REG_THRESHOLD     = 3'd3;
    localparam logic [2:0] REG_SEL_RED       = 3'd4;
    localparam logic [2:0] REG_SEL_GREEN     = 3'd5;
    localparam logic [2:0] REG_SEL_BLUE      = 3'd6;
    localparam logic [2:0] REG_STRIP_OFFSET  = 3'd7;

    localparam logic [8:0] THRESHOLD_RST = 9'd20;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] profile;
    } map_cfg_t;

    // (11R + 16G + 5B) / 32, truncated
    function automatic logic [PIX_W-1:0] luma(input pix_t p);
        logic [12:0] s;
        s = 13'({p.red, 3'b000}) + 13'({p.red, 1'b0}) + 13'(p.red)
          + 13'({p.green, 4'b0000})
          + 13'({p.blue, 2'b00}) + 13'(p.blue);
        return s[12:5];
    endfunction

endpackage

// ===== rtl/core/cvpm_strip.sv =====
// Strip channel index: ((row + offset) / STRIP_HEIGHT) mod 3 over four stages.
module cvpm_strip
    import cvpm_pkg::*;
#(
    parameter int STRIP_HEIGHT = STRIP_HEIGHT_DEF,
    parameter int ROW_BITS     = ROW_BITS_DEF
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [ROW_BITS-1:0] row,
    input  logic [ROW_BITS-1:0] offset,
    output logic [1:0]          strip_ch
);

    localparam int SUM_W  = ROW_BITS + 1;
    localparam int RCP    = (1 << SUM_W) / STRIP_HEIGHT;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int HGT_W  = 11;
    localparam int CHK_W  = SUM_W + HGT_W;
    localparam int DIG    = (SUM_W + 1) / 2;

    localparam logic [RCP_W-1:0] RCP_C = RCP_W'(RCP);
    localparam logic [CHK_W-1:0] HGT_C = CHK_W'(STRIP_HEIGHT);

    // mod 3 by summing base-4 digits (4 = 1 mod 3), then a small fold
    function automatic logic [1:0] mod3(input logic [SUM_W-1:0] v);
        logic [SUM_W:0] vx;
        logic [5:0]     s1;
        logic [3:0]     s2;
        vx = {1'b0, v};
        s1 = '0;
        for (int i = 0; i < DIG; i++) begin
            s1 = s1 + 6'(vx[2*i +: 2]);
        end
        s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
        if (s2 >= 4'd6) begin
            s2 = s2 - 4'd6;
        end
        if (s2 >= 4'd3) begin
            s2 = s2 - 4'd3;
        end
        return s2[1:0];
    endfunction

    logic [SUM_W-1:0]  sum_next, sum_reg, sum2_reg;
    logic [PROD_W-1:0] prod_next, prod_reg;
    logic [SUM_W-1:0]  q_est;
    logic [CHK_W-1:0]  back, remd;
    logic [SUM_W-1:0]  q_next, q_reg;
    logic [1:0]        ch_next, ch_reg;

    assign sum_next  = {1'b0, row} + {1'b0, offset};
    // estimate is exact or one short
    assign prod_next = {{RCP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RCP_C};
    assign q_est     = prod_reg[SUM_W +: SUM_W];
    assign back      = {{HGT_W{1'b0}}, q_est} * HGT_C;
    assign remd      = {{HGT_W{1'b0}}, sum2_reg} - back;
    assign q_next    = (remd >= HGT_C) ? q_est + 1'b1 : q_est;
    assign ch_next   = mod3(q_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            prod_reg <= prod_next;
            sum2_reg <= sum_reg;
            q_reg    <= q_next;
            ch_reg   <= ch_next;
        end
    end

    assign strip_ch = ch_reg;

endmodule

// ===== rtl/core/cvpm_mode_map.sv =====
// Display mode stage: maps the source pixel to the selected view.
module cvpm_mode_map
    import cvpm_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  pix_t     pix,
    input  logic [1:0] strip_ch,
    input  map_cfg_t cfg,
    output pix_t     res
);

    function automatic logic [PIX_W-1:0] pick(input pix_t p, input logic [1:0] sel);
        logic [PIX_W-1:0] v;
        unique case (sel)
            CH_RED:   v = p.red;
            CH_GREEN: v = p.green;
            CH_BLUE:  v = p.blue;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] sub_clamp(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    logic [PIX_W:0]   rg_sum;
    logic [PIX_W-1:0] rg_avg, yb, gray;
    pix_t             res_next, res_reg;

    assign rg_sum = {1'b0, pix.red} + {1'b0, pix.green};
    assign rg_avg = rg_sum[PIX_W:1];
    assign yb     = sub_clamp(rg_avg, pix.blue);

    always_comb
    begin
        gray     = '0;
        res_next = pix;
        unique case (cfg.mode)
            MODE_ORIG:     res_next = pix;
            MODE_RED:      res_next = '{red: pix.red, green: '0, blue: '0};
            MODE_GREEN:    res_next = '{red: '0, green: pix.green, blue: '0};
            MODE_BLUE:     res_next = '{red: '0, green: '0, blue: pix.blue};
            MODE_CONE:
            begin
                gray     = pick(pix, cfg.profile);
                res_next = '{red: gray, green: gray, blue: gray};
            end
            MODE_LUMA:
            begin
                gray     = luma(pix);
                res_next = '{red: gray, green: gray, blue: gray};
            end
            MODE_RG_DIFF:
            begin
                gray     = sub_clamp(pix.red, pix.green);
                res_next = '{red: gray, green: gray, blue: gray};
            end
            MODE_RG_AVG:   res_next = '{red: rg_avg, green: rg_avg, blue: '0};
            MODE_YB_GRAY:  res_next = '{red: yb, green: yb, blue: yb};
            MODE_YB_YEL:   res_next = '{red: yb, green: yb, blue: '0};
            MODE_R_HALF_G:
            begin
                gray     = sub_clamp(pix.red, {1'b0, pix.green[PIX_W-1:1]});
                res_next = '{red: gray, green: gray, blue: gray};
            end
            MODE_STRIP:
            begin
                gray     = pick(pix, strip_ch);
                res_next = '{red: gray, green: gray, blue: gray};
            end
            default:       res_next = pix;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/cvpm_tool.sv =====
// Dark/light tool stage: replaces unlike pixels with shifted, clamped gray.
module cvpm_tool
    import cvpm_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  pix_t       pix,
    input  logic       unlike,
    input  logic [1:0] tool,
    output pix_t       res
);

    logic [PIX_W-1:0] gy, shifted;
    logic [PIX_W:0]   up;
    pix_t             res_next, res_reg;

    assign gy = luma(pix);
    assign up = {1'b0, gy} + (PIX_W+1)'(TOOL_SHIFT);

    always_comb
    begin
        shifted  = gy;
        res_next = pix;
        unique case (tool)
            TOOL_DARK:
            begin
                shifted = (gy > PIX_W'(TOOL_SHIFT)) ? gy - PIX_W'(TOOL_SHIFT) : '0;
                if (unlike)
                begin
                    res_next = '{red: shifted, green: shifted, blue: shifted};
                end
            end
            TOOL_LIGHT:
            begin
                shifted = (up > (PIX_W+1)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : up[PIX_W-1:0];
                if (unlike)
                begin
                    res_next = '{red: shifted, green: shifted, blue: shifted};
                end
            end
            default:    res_next = pix;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/color_vision_pixel_mode_mapper_top.sv =====
// Top level of the color vision pixel mode mapper: config, pipeline control, stages.
// Depth: six register stages from request accept to result on m_tdata.
// Throughput: one pixel per cycle; the whole pipe advances when the output slot is
//   empty or taken, so a stall on m_tready freezes every stage without loss.
// Reset: rst_n async, active low; clears all valid bits and the config registers
//   (threshold resets to 20, everything else to 0). No clearing pass is needed.
module color_vision_pixel_mode_mapper_top
    import cvpm_pkg::*;
#(
    parameter int STRIP_HEIGHT = STRIP_HEIGHT_DEF,
    parameter int ROW_BITS     = ROW_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    // request side
    input  logic s_tvalid,
    output logic s_tready,
    // [7:0] in_red, [15:8] in_green, [23:16] in_blue, [23+ROW_BITS:24] row, rest zero
    input  logic [((24 + ROW_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0] m_tdata,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [(ROW_BITS > 9 ? ROW_BITS : 9) - 1:0] cfg_wdata
);

    localparam int STAGES = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]          mode_reg;
    logic [1:0]          profile_reg;
    logic [1:0]          tool_reg;
    logic [8:0]          thresh_reg;
    logic [PIX_W-1:0]    sel_red_reg, sel_green_reg, sel_blue_reg;
    logic [ROW_BITS-1:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ORIG;
            profile_reg   <= CH_RED;
            tool_reg      <= TOOL_NONE;
            thresh_reg    <= THRESHOLD_RST;
            sel_red_reg   <= '0;
            sel_green_reg <= '0;
            sel_blue_reg  <= '0;
            offset_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MODE:          mode_reg      <= cfg_wdata[3:0];
                REG_COLOR_PROFILE: profile_reg   <= cfg_wdata[1:0];
                REG_TOOL:          tool_reg      <= cfg_wdata[1:0];
                REG_THRESHOLD:     thresh_reg    <= cfg_wdata[8:0];
                REG_SEL_RED:       sel_red_reg   <= cfg_wdata[7:0];
                REG_SEL_GREEN:     sel_green_reg <= cfg_wdata[7:0];
                REG_SEL_BLUE:      sel_blue_reg  <= cfg_wdata[7:0];
                REG_STRIP_OFFSET:  offset_reg    <= cfg_wdata[ROW_BITS-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one global advance, valid bits travel with data
    // ------------------------------------------------------------------
    logic              en;
    logic [STAGES-1:0] vld_reg;

    assign en       = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    pix_t                in_pix;
    logic [ROW_BITS-1:0] in_row;

    assign in_pix = '{red:   s_tdata[7:0],
                      green: s_tdata[15:8],
                      blue:  s_tdata[23:16]};
    assign in_row = s_tdata[24 +: ROW_BITS];

    // ------------------------------------------------------------------
    // Pixel carry (stages 1..4) and the distance check for the tool.
    // Stage 1 holds the per-channel distances, stage 2 the compare result,
    // which then rides along to the tool stage.
    // ------------------------------------------------------------------
    pix_t             pix_reg [4];
    logic [PIX_W-1:0] dr_next, dg_next, db_next;
    logic [PIX_W-1:0] dr_reg, dg_reg, db_reg;
    logic [PIX_W+1:0] dist_sum;
    logic             unl_next;
    logic [3:0]       unl_reg;

    assign dr_next = (in_pix.red > sel_red_reg) ? in_pix.red - sel_red_reg
                                                : sel_red_reg - in_pix.red;
    assign dg_next = (in_pix.green > sel_green_reg) ? in_pix.green - sel_green_reg
                                                    : sel_green_reg - in_pix.green;
    assign db_next = (in_pix.blue > sel_blue_reg) ? in_pix.blue - sel_blue_reg
                                                  : sel_blue_reg - in_pix.blue;
    assign dist_sum = (PIX_W+2)'(dr_reg) + (PIX_W+2)'(dg_reg) + (PIX_W+2)'(db_reg);
    assign unl_next = dist_sum > (PIX_W+2)'(thresh_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg[0] <= in_pix;
            pix_reg[1] <= pix_reg[0];
            pix_reg[2] <= pix_reg[1];
            pix_reg[3] <= pix_reg[2];
            dr_reg     <= dr_next;
            dg_reg     <= dg_next;
            db_reg     <= db_next;
            unl_reg    <= {unl_reg[2:0], unl_next};
        end
    end

    // ------------------------------------------------------------------
    // Strip channel: sum, reciprocal multiply, correction, mod 3 (stages 1..4)
    // ------------------------------------------------------------------
    logic [1:0] strip_ch;

    cvpm_strip #(
        .STRIP_HEIGHT (STRIP_HEIGHT),
        .ROW_BITS     (ROW_BITS)
    ) u_strip (
        .clk      (clk),
        .en       (en),
        .row      (in_row),
        .offset   (offset_reg),
        .strip_ch (strip_ch)
    );

    // ------------------------------------------------------------------
    // Mode map (stage 5) and tool (stage 6, output register)
    // ------------------------------------------------------------------
    map_cfg_t map_cfg;
    pix_t     mapped, result;

    assign map_cfg = '{mode: mode_reg, profile: profile_reg};

    cvpm_mode_map u_mode_map (
        .clk      (clk),
        .en       (en),
        .pix      (pix_reg[3]),
        .strip_ch (strip_ch),
        .cfg      (map_cfg),
        .res      (mapped)
    );

    cvpm_tool u_tool (
        .clk    (clk),
        .en     (en),
        .pix    (mapped),
        .unlike (unl_reg[3]),
        .tool   (tool_reg),
        .res    (result)
    );

    assign m_tdata = {result.blue, result.green, result.red};

endmodule

// ===== dv/color_vision_pixel_mode_mapper_top_tb.sv =====
// Self-checking testbench for the color vision pixel mode mapper top level.
`timescale 1ns / 1ps

module color_vision_pixel_mode_mapper_top_tb;
    import cvpm_pkg::*;

    // Block pipeline depth, request accept to result (from the top-level header)
    localparam int LATENCY      = 6;
    localparam int PHASE_ITEMS  = 95;
    localparam int NUM_PHASES   = 14;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TDATA_W      = ((24 + ROW_BITS_DEF + 7) / 8) * 8;
    localparam int CFG_W        = ROW_BITS_DEF > 9 ? ROW_BITS_DEF : 9;

    // One directed request with the settings it runs under. Where "known" is set the
    // expected pixel is typed in; otherwise the predictor supplies it.
    typedef struct {
        logic [3:0]              mode;
        logic [1:0]              profile;
        logic [1:0]              tool;
        logic [8:0]              thr;
        logic [11:0]             offset;
        pix_t                    px;
        logic [ROW_BITS_DEF-1:0] row;
        bit                      known;
        pix_t                    want;
    } dir_step_t;

    localparam int DIR_N = 25;

    dir_step_t dir_steps [DIR_N] = '{
        // reset settings: pixels pass through, field extremes
        '{MODE_ORIG, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd255, 8'd255, 8'd255}, 12'hFFF,
          1'b1, '{8'd255, 8'd255, 8'd255}},
        '{MODE_ORIG, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd0, 8'd0, 8'd0}, 12'h000,
          1'b1, '{8'd0, 8'd0, 8'd0}},
        // channel masks
        '{MODE_RED, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd200, 8'd100, 8'd50}, 12'hA5A,
          1'b1, '{8'd200, 8'd0, 8'd0}},
        '{MODE_GREEN, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd200, 8'd100, 8'd50}, 12'h5A5,
          1'b1, '{8'd0, 8'd100, 8'd0}},
        '{MODE_BLUE, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd200, 8'd100, 8'd50}, 12'h123,
          1'b1, '{8'd0, 8'd0, 8'd50}},
        // cone, every profile including the unused one (gray 0)
        '{MODE_CONE, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd10, 8'd20, 8'd30}, 12'd0,
          1'b1, '{8'd10, 8'd10, 8'd10}},
        '{MODE_CONE, CH_GREEN, TOOL_NONE, 9'd20, 12'd0, '{8'd10, 8'd20, 8'd30}, 12'd0,
          1'b1, '{8'd20, 8'd20, 8'd20}},
        '{MODE_CONE, CH_BLUE, TOOL_NONE, 9'd20, 12'd0, '{8'd10, 8'd20, 8'd30}, 12'd0,
          1'b1, '{8'd30, 8'd30, 8'd30}},
        '{MODE_CONE, 2'd3, TOOL_NONE, 9'd20, 12'd0, '{8'd10, 8'd20, 8'd30}, 12'd0,
          1'b1, '{8'd0, 8'd0, 8'd0}},
        // luminance: white stays white, midtones from the predictor
        '{MODE_LUMA, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd255, 8'd255, 8'd255}, 12'd0,
          1'b1, '{8'd255, 8'd255, 8'd255}},
        '{MODE_LUMA, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd100, 8'd150, 8'd200}, 12'd0,
          1'b0, '{8'd0, 8'd0, 8'd0}},
        // opponent channels, negative differences clamp
        '{MODE_RG_DIFF, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd50, 8'd200, 8'd0}, 12'd0,
          1'b1, '{8'd0, 8'd0, 8'd0}},
        '{MODE_RG_AVG, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd255, 8'd255, 8'd77}, 12'd0,
          1'b1, '{8'd255, 8'd255, 8'd0}},
        '{MODE_YB_GRAY, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd100, 8'd100, 8'd255}, 12'd0,
          1'b1, '{8'd0, 8'd0, 8'd0}},
        '{MODE_YB_YEL, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd201, 8'd99, 8'd30}, 12'd0,
          1'b0, '{8'd0, 8'd0, 8'd0}},
        '{MODE_R_HALF_G, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd10, 8'd255, 8'd0}, 12'd0,
          1'b1, '{8'd0, 8'd0, 8'd0}},
        '{MODE_R_HALF_G, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd255, 8'd0, 8'd9}, 12'd0,
          1'b1, '{8'd255, 8'd255, 8'd255}},
        // strips: first strip red, second green, max row plus max offset without wrap
        '{MODE_STRIP, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd1, 8'd2, 8'd3}, 12'd0,
          1'b1, '{8'd1, 8'd1, 8'd1}},
        '{MODE_STRIP, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd1, 8'd2, 8'd3}, 12'd64,
          1'b1, '{8'd2, 8'd2, 8'd2}},
        '{MODE_STRIP, CH_RED, TOOL_NONE, 9'd20, 12'd4095, '{8'd1, 8'd2, 8'd3}, 12'hFFF,
          1'b0, '{8'd0, 8'd0, 8'd0}},
        // unused mode code passes the pixel through
        '{4'd15, CH_RED, TOOL_NONE, 9'd20, 12'd0, '{8'd12, 8'd34, 8'd56}, 12'd0,
          1'b1, '{8'd12, 8'd34, 8'd56}},
        // tools against black: far pixel darkened, near pixel untouched
        '{MODE_ORIG, CH_RED, TOOL_DARK, 9'd20, 12'd0, '{8'd255, 8'd255, 8'd255}, 12'd0,
          1'b1, '{8'd195, 8'd195, 8'd195}},
        '{MODE_ORIG, CH_RED, TOOL_DARK, 9'd20, 12'd0, '{8'd5, 8'd5, 8'd5}, 12'd0,
          1'b1, '{8'd5, 8'd5, 8'd5}},
        // threshold 0: any difference counts; light lifts gray 0 to 60
        '{MODE_ORIG, CH_RED, TOOL_LIGHT, 9'd0, 12'd0, '{8'd0, 8'd0, 8'd1}, 12'd0,
          1'b1, '{8'd60, 8'd60, 8'd60}},
        // unused tool code does nothing
        '{MODE_ORIG, CH_RED, 2'd3, 9'd0, 12'd0, '{8'd9, 8'd8, 8'd7}, 12'd0,
          1'b1, '{8'd9, 8'd8, 8'd7}}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic                cfg_wr_en;
    logic [2:0]          cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    color_vision_pixel_mode_mapper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the block's settings, updated on every register write
    logic [3:0]  set_mode;
    logic [1:0]  set_profile;
    logic [1:0]  set_tool;
    logic [8:0]  set_thr;
    pix_t        set_ref;
    logic [11:0] set_offset;

    // Pixels the block still owes us, oldest first
    pix_t expected_pixels [$];

    int  mismatches     = 0;
    int  requests_sent  = 0;
    int  pixels_checked = 0;
    int  stall_cycles   = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    bit  sender_gaps    = 1'b1;
    bit  hold_req       = 1'b0;
    bit  [15:0] modes_seen = '0;

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------

    // (11R + 16G + 5B) / 32, truncated
    function automatic logic [7:0] gray_of(input pix_t p);
        logic [12:0] acc;
        acc = 13'd11 * p.red + 13'd16 * p.green + 13'd5 * p.blue;
        return acc[12:5];
    endfunction

    function automatic logic [7:0] channel_of(input pix_t p, input logic [1:0] sel);
        case (sel)
            CH_RED:   return p.red;
            CH_GREEN: return p.green;
            CH_BLUE:  return p.blue;
            default:  return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : 8'd0;
    endfunction

    function automatic logic [7:0] abs_sub(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic pix_t map_pixel(input pix_t src, input logic [11:0] row);
        pix_t        o;
        logic [7:0]  v;
        logic [7:0]  gy;
        logic [8:0]  rg_sum;
        logic [8:0]  lifted;
        logic [9:0]  color_dist;
        logic [12:0] strip_sum;
        int          strip_line;
        o      = src;
        rg_sum = src.red + src.green;
        case (set_mode)
            MODE_RED:      o = '{src.red, 8'd0, 8'd0};
            MODE_GREEN:    o = '{8'd0, src.green, 8'd0};
            MODE_BLUE:     o = '{8'd0, 8'd0, src.blue};
            MODE_CONE:
            begin
                v = channel_of(src, set_profile);
                o = '{v, v, v};
            end
            MODE_LUMA:
            begin
                v = gray_of(src);
                o = '{v, v, v};
            end
            MODE_RG_DIFF:
            begin
                v = sat_sub(src.red, src.green);
                o = '{v, v, v};
            end
            MODE_RG_AVG:   o = '{rg_sum[8:1], rg_sum[8:1], 8'd0};
            MODE_YB_GRAY:
            begin
                v = sat_sub(rg_sum[8:1], src.blue);
                o = '{v, v, v};
            end
            MODE_YB_YEL:
            begin
                v = sat_sub(rg_sum[8:1], src.blue);
                o = '{v, v, 8'd0};
            end
            MODE_R_HALF_G:
            begin
                v = sat_sub(src.red, src.green >> 1);
                o = '{v, v, v};
            end
            MODE_STRIP:
            begin
                // sum formed one bit wider than the row, no wrap
                strip_sum  = row + set_offset;
                strip_line = int'(strip_sum) / STRIP_HEIGHT_DEF;
                v = channel_of(src, 2'(strip_line % 3));
                o = '{v, v, v};
            end
            default:       o = src;
        endcase

        // distance is taken from the source pixel, gray from the mode result
        if (set_tool == TOOL_DARK || set_tool == TOOL_LIGHT)
        begin
            color_dist = abs_sub(src.red, set_ref.red) + abs_sub(src.green, set_ref.green)
                       + abs_sub(src.blue, set_ref.blue);
            if (color_dist > set_thr)
            begin
                gy = gray_of(o);
                if (set_tool == TOOL_DARK)
                    gy = sat_sub(gy, 8'(TOOL_SHIFT));
                else
                begin
                    lifted = gy + 9'(TOOL_SHIFT);
                    gy = (lifted > PIX_MAX) ? 8'(PIX_MAX) : lifted[7:0];
                end
                o = '{gy, gy, gy};
            end
        end
        return o;
    endfunction

    // ---------------------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------------------

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:          set_mode      = val[3:0];
            REG_COLOR_PROFILE: set_profile   = val[1:0];
            REG_TOOL:          set_tool      = val[1:0];
            REG_THRESHOLD:     set_thr       = val[8:0];
            REG_SEL_RED:       set_ref.red   = val[7:0];
            REG_SEL_GREEN:     set_ref.green = val[7:0];
            REG_SEL_BLUE:      set_ref.blue  = val[7:0];
            REG_STRIP_OFFSET:  set_offset    = val[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [3:0] mode, input logic [1:0] profile,
                                 input logic [1:0] tool, input logic [8:0] thr,
                                 input pix_t ref_px, input logic [11:0] offset);
        write_reg(REG_MODE, CFG_W'(mode));
        write_reg(REG_COLOR_PROFILE, CFG_W'(profile));
        write_reg(REG_TOOL, CFG_W'(tool));
        write_reg(REG_THRESHOLD, CFG_W'(thr));
        write_reg(REG_SEL_RED, CFG_W'(ref_px.red));
        write_reg(REG_SEL_GREEN, CFG_W'(ref_px.green));
        write_reg(REG_SEL_BLUE, CFG_W'(ref_px.blue));
        write_reg(REG_STRIP_OFFSET, CFG_W'(offset));
    endtask

    // Settings change only with the pipe empty: drop valid, let every owed pixel
    // come back, then let the pipe settle.
    task automatic wait_pipe_empty();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Request side: bursts of back-to-back requests, separated by random gaps when sender_gaps is set.
    // Valid is only ever changed at a falling edge, once per edge.
    // ---------------------------------------------------------------------------------

    task automatic send_pixel(input pix_t px, input logic [11:0] row, input pix_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 10);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tdata  <= {{(TDATA_W - 24 - ROW_BITS_DEF){1'b0}}, row, px.blue, px.green, px.red};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_pixels.push_back(want);
        requests_sent++;
        modes_seen[set_mode] = 1'b1;
    endtask

    // ---------------------------------------------------------------------------------
    // Result side: ready follows a random style that is picked anew at random intervals, and
    // on request goes low for a long stretch so the pipe fills and backs up.
    // ---------------------------------------------------------------------------------

    initial
    begin
        int style;
        int style_left;
        int tick;
        m_tready   = 1'b0;
        style      = 0;
        style_left = 0;
        tick       = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                tick++;
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ((tick % 7) < 4);
                    default: m_tready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Result checker and run watchdog
    // ---------------------------------------------------------------------------------

    always @(posedge clk)
    begin
        pix_t got;
        pix_t exp_px;
        if (rst_n)
        begin
            cycle_count++;
            if (s_tvalid && !s_tready)
                stall_cycles++;
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]};
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: result with none owed: got r=%0d g=%0d b=%0d",
                             $time, got.red, got.green, got.blue);
                    mismatches++;
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got.red !== exp_px.red)
                    begin
                        $display("%0t: out_red expected %0d got %0d", $time, exp_px.red,
                                 got.red);
                        mismatches++;
                    end
                    if (got.green !== exp_px.green)
                    begin
                        $display("%0t: out_green expected %0d got %0d", $time,
                                 exp_px.green, got.green);
                        mismatches++;
                    end
                    if (got.blue !== exp_px.blue)
                    begin
                        $display("%0t: out_blue expected %0d got %0d", $time,
                                 exp_px.blue, got.blue);
                        mismatches++;
                    end
                end
            end
            if (cycle_count == CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results still owed", $time,
                         expected_pixels.size());
                $display("color_vision_pixel_mode_mapper_top regression: fail");
                $finish;
            end
        end
    end

    // Pixel aimed near the reference color, so the threshold compare lands on both sides
    function automatic logic [7:0] near(input logic [7:0] c);
        int t;
        t = int'(c) + $urandom_range(0, 24) - 12;
        return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------

    initial
    begin
        pix_t        px;
        pix_t        ref_px;
        logic [11:0] row;
        logic [3:0]  mode;
        logic [1:0]  tool;
        logic [8:0]  thr;
        logic [11:0] offset;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_MODE;
        cfg_wdata = '0;

        // shadow settings start at their reset values
        set_mode    = MODE_ORIG;
        set_profile = CH_RED;
        set_tool    = TOOL_NONE;
        set_thr     = THRESHOLD_RST;
        set_ref     = '{8'd0, 8'd0, 8'd0};
        set_offset  = 12'd0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: reload settings only when a step needs different ones
        foreach (dir_steps[i])
        begin
            if (dir_steps[i].mode != set_mode || dir_steps[i].profile != set_profile ||
                dir_steps[i].tool != set_tool || dir_steps[i].thr != set_thr ||
                dir_steps[i].offset != set_offset)
            begin
                wait_pipe_empty();
                load_settings(dir_steps[i].mode, dir_steps[i].profile, dir_steps[i].tool,
                              dir_steps[i].thr, '{8'd0, 8'd0, 8'd0}, dir_steps[i].offset);
            end
            send_pixel(dir_steps[i].px, dir_steps[i].row,
                       dir_steps[i].known ? dir_steps[i].want
                                          : map_pixel(dir_steps[i].px, dir_steps[i].row));
        end

        // Random part: one settings phase per mode, then unused and random mode codes
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            mode = (ph < 12) ? 4'(ph) : (ph == 12) ? 4'($urandom_range(12, 15))
                                                   : 4'($urandom_range(0, 15));
            tool = (ph % 5 == 4) ? 2'($urandom_range(0, 3))
                                 : (ph % 2 == 1) ? TOOL_DARK : TOOL_LIGHT;
            case ($urandom_range(0, 6))
                0:       thr = 9'd0;
                1:       thr = 9'd1;
                2:       thr = 9'd20;
                3:       thr = 9'd509;
                4:       thr = 9'd510;
                5:       thr = 9'd511;
                default: thr = 9'($urandom_range(0, 511));
            endcase
            offset = ($urandom_range(0, 3) == 0) ? 12'd4095
                   : ($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
            ref_px = '{rand_level(), rand_level(), rand_level()};

            wait_pipe_empty();
            load_settings(mode, 2'($urandom_range(0, 3)), tool, thr, ref_px, offset);

            // every fourth phase runs the request side flat out
            sender_gaps = (ph % 4 != 3);
            // one phase holds results back long enough to back up the input
            if (ph == 5)
                hold_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 2))
                    0:       px = '{near(set_ref.red), near(set_ref.green),
                                    near(set_ref.blue)};
                    1:       px = '{8'($urandom), 8'($urandom), 8'($urandom)};
                    default: px = '{rand_level(), rand_level(), rand_level()};
                endcase
                // a quarter of the rows sit on a strip boundary after the offset
                if ($urandom_range(0, 3) == 0)
                    row = 12'($urandom_range(0, 127) * STRIP_HEIGHT_DEF - int'(set_offset)
                              - $urandom_range(0, 1));
                else
                    row = 12'($urandom_range(0, 4095));
                send_pixel(px, row, map_pixel(px, row));
            end
        end

        // drain and let the pipe sit idle for a while to catch stray results
        wait_pipe_empty();
        repeat (4 * LATENCY) @(posedge clk);
        if (expected_pixels.size() != 0)
            mismatches++;

        $display("Covered %0d requests, %0d results checked, %0d input stall cycles,",
                 requests_sent, pixels_checked, stall_cycles);
        $display("mode codes seen mask %04h, %0d settings phases after the directed steps.",
                 modes_seen, NUM_PHASES);
        if (mismatches == 0)
            $display("color_vision_pixel_mode_mapper_top regression: pass");
        else
            $display("color_vision_pixel_mode_mapper_top regression: fail");
        $finish;
    end

endmodule
